// ===== hw/rtl/lrc_pkg.sv =====
package lrc_pkg;

	localparam logic KIND_WEIGHT  = 1'b0;
	localparam logic KIND_FEATURE = 1'b1;

	localparam int SIG_POINTS = 257;
	localparam longint unsigned EXP_STEP_Q32 = 64'd4034748382;
	localparam longint unsigned ONE_Q32 = 64'd4294967296;

	localparam logic signed [31:0] SIG_LOW_EDGE  = -32'sd524288;
	localparam logic signed [31:0] SIG_HIGH_EDGE = 32'sd524288;
	localparam logic [15:0] PROB_MAX = 16'hFFFF;

	typedef logic [15:0] sig_tbl_t [0:SIG_POINTS-1];

	typedef struct packed {
		logic               valid;
		logic               too_many;
		logic signed [31:0] score;
	} lrc_res_t;

	// restoring shift-subtract quotient, elaboration only
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned dvs);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= dvs) begin
				rem = rem - dvs;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sigmoid points at x = -8 + i/16, Q0.16, built at elaboration.
	function automatic sig_tbl_t build_sig_table();
		sig_tbl_t        tbl;
		longint unsigned e;
		longint unsigned den;
		longint unsigned lo;
		longint unsigned hi;
		e = ONE_Q32;
		for (int k = 0; k <= 128; k++) begin
			if (k > 0) begin
				e = (e * EXP_STEP_Q32 + 64'd2147483648) >> 32;
			end
			den = ONE_Q32 + e;
			lo = udiv64((e << 16) + (den >> 1), den);
			hi = udiv64((ONE_Q32 << 16) + (den >> 1), den);
			if (lo > 64'd65535) begin
				lo = 64'd65535;
			end
			if (hi > 64'd65535) begin
				hi = 64'd65535;
			end
			tbl[128 - k] = lo[15:0];
			tbl[128 + k] = hi[15:0];
		end
		return tbl;
	endfunction

	localparam sig_tbl_t SIG_TABLE = build_sig_table();

endpackage

// ===== hw/rtl/lrc_sigmoid.sv =====
module lrc_sigmoid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  lrc_pkg::lrc_res_t res_in,
	output lrc_pkg::lrc_res_t res_out,
	output logic [15:0]       probability
);

	logic signed [32:0] t_full;
	logic [7:0]         idx;
	logic [8:0]         idx_next;
	logic [15:0]        pt_a;
	logic [15:0]        pt_b;
	logic [15:0]        a_sel;
	logic [15:0]        d_sel;

	lrc_pkg::lrc_res_t  res_s3;
	lrc_pkg::lrc_res_t  res_s4;
	logic [15:0]        a_s4;
	logic [15:0]        diff_s4;
	logic [11:0]        frac_s4;
	logic [27:0]        interp;
	logic [15:0]        prob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= '0;
		end else if (adv) begin
			res_s3 <= res_in;
		end
	end

	assign t_full   = 33'(res_s3.score) + 33'sd524288;
	assign idx      = t_full[19:12];
	assign idx_next = {1'b0, idx} + 9'd1;
	assign pt_a     = lrc_pkg::SIG_TABLE[idx];
	assign pt_b     = lrc_pkg::SIG_TABLE[idx_next];

	always_comb begin
		if (res_s3.score < lrc_pkg::SIG_LOW_EDGE) begin
			a_sel = 16'd0;
			d_sel = 16'd0;
		end else if (res_s3.score >= lrc_pkg::SIG_HIGH_EDGE) begin
			a_sel = lrc_pkg::PROB_MAX;
			d_sel = 16'd0;
		end else begin
			a_sel = pt_a;
			d_sel = (pt_b >= pt_a) ? (pt_b - pt_a) : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s4  <= '0;
			res_out <= '0;
		end else if (adv) begin
			res_s4  <= res_s3;
			res_out <= res_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4    <= a_sel;
			diff_s4 <= d_sel;
			frac_s4 <= t_full[11:0];
			prob_q  <= a_s4 + 16'(interp >> 12);
		end
	end

	assign interp      = diff_s4 * frac_s4;
	assign probability = prob_q;

endmodule

// ===== hw/rtl/logistic_regression_classifier_top.sv =====
// An accepted last_feature transaction passes registers s1, s2, s3, s4 and res_out to its result.
// Throughput: one transaction per cycle while in_stall is low; the 40-bit accumulate loop and the weight
// memory's single read port each serve one feature per cycle.
// in_stall rises only while a result is held in the output register under out_stall.
// Reset clears pipeline valids, the running sum, position and overflow flag;
// the weight memory is undefined until written.
module logistic_regression_classifier_top #(
	parameter int MAX_FEATURES = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [5:0]         weight_index,
	input  logic signed [15:0] sample_value,
	input  logic               last_feature,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        probability,
	output logic signed [31:0] score,
	output logic               too_many_features
);

	localparam int LIMIT = (MAX_FEATURES < 63) ? MAX_FEATURES : 63;
	localparam logic [5:0] LIMIT_POS = 6'(LIMIT);
	localparam logic signed [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] SUM_MIN = {1'b1, {39{1'b0}}};

	logic        adv;
	logic        accept;
	logic        wr_en;
	logic        feat;
	logic        acc_now;
	logic [5:0]  rd_addr;

	logic [15:0] weight_mem_q [0:63];
	logic signed [15:0] rdata_q;
	logic signed [15:0] bias_q;
	logic [5:0]  pos_q;
	logic        ovf_q;

	logic               v_s1;
	logic               acc_s1;
	logic               first_s1;
	logic               last_s1;
	logic               ovf_s1;
	logic signed [15:0] value_s1;
	logic signed [15:0] bias_s1;

	logic               v_s2;
	logic               acc_s2;
	logic               first_s2;
	logic               last_s2;
	logic               ovf_s2;
	logic signed [31:0] prod_s2;
	logic signed [15:0] bias_s2;

	logic signed [39:0] sum_q;
	logic signed [40:0] base;
	logic signed [40:0] sum_wide;
	logic signed [39:0] sum_sat;
	logic signed [39:0] sum_new;

	lrc_pkg::lrc_res_t res_s2;
	lrc_pkg::lrc_res_t res_out;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign wr_en    = accept && (kind == lrc_pkg::KIND_WEIGHT);
	assign feat     = accept && (kind == lrc_pkg::KIND_FEATURE);
	assign acc_now  = pos_q < LIMIT_POS;
	assign rd_addr  = 6'(pos_q + 6'd1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			weight_mem_q[weight_index] <= sample_value;
		end
		if (adv) begin
			rdata_q <= weight_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (weight_index == 6'd0)) begin
			bias_q <= sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (feat) begin
			if (last_feature) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else if (acc_now) begin
				pos_q <= pos_q + 6'd1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= feat;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s1   <= acc_now;
			first_s1 <= (pos_q == 6'd0);
			last_s1  <= last_feature;
			ovf_s1   <= ovf_q || !acc_now;
			value_s1 <= sample_value;
			bias_s1  <= bias_q;

			acc_s2   <= acc_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			ovf_s2   <= ovf_s1;
			prod_s2  <= value_s1 * rdata_q;
			bias_s2  <= bias_s1;
		end
	end

	// bias * 1.0 in Q16.16 on the first feature
	assign base     = first_s2 ? 41'($signed({bias_s2, 8'd0})) : 41'(sum_q);
	assign sum_wide = base + 41'(prod_s2);

	always_comb begin
		if (sum_wide[40] != sum_wide[39]) begin
			sum_sat = sum_wide[40] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_wide[39:0];
		end
	end

	assign sum_new = (v_s2 && acc_s2) ? sum_sat : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv && v_s2 && acc_s2) begin
			sum_q <= sum_sat;
		end
	end

	always_comb begin
		res_s2.valid    = v_s2 && last_s2;
		res_s2.too_many = ovf_s2;
		if ((sum_new[39:31] != 9'h000) && (sum_new[39:31] != 9'h1FF)) begin
			res_s2.score = sum_new[39] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			res_s2.score = sum_new[31:0];
		end
	end

	lrc_sigmoid u_sigmoid (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.res_in      (res_s2),
		.res_out     (res_out),
		.probability (probability)
	);

	assign out_valid         = res_out.valid;
	assign score             = res_out.score;
	assign too_many_features = res_out.too_many;

endmodule

// ===== hw/rtl/lrc_checker.sv =====
module lrc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [15:0]        probability,
	input logic signed [31:0] score,
	input logic               too_many_features
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(probability) && $stable(score)
			&& $stable(too_many_features))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_clamp_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (score < -32'sd524288) |-> probability == 16'd0)
		else $error("probability not zero below range");

	a_clamp_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (score >= 32'sd524288) |-> probability == 16'hFFFF)
		else $error("probability not saturated above range");

endmodule

bind logistic_regression_classifier_top lrc_checker u_lrc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.probability       (probability),
	.score             (score),
	.too_many_features (too_many_features)
);
